>>> hdl/sphere_zone_entry_detector_assert.svh
`ifndef SPHERE_ZONE_ENTRY_DETECTOR_ASSERT_SVH
`define SPHERE_ZONE_ENTRY_DETECTOR_ASSERT_SVH

// same-cycle implication under reset
`define SZED_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sphere zone detector check failed");

// next-cycle implication under reset
`define SZED_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sphere zone detector check failed");

`endif

>>> hdl/szed_pkg.sv
package szed_pkg;

	localparam int POS_W = 24;
	localparam int MODE_W = 2;
	localparam int CD_W = 8;
	localparam int RAD_W = 21;
	localparam int RSQ_W = 41;
	localparam int SQ_W = 2 * POS_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int IDX_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int NRES_W = 7;

	localparam logic [NRES_W-1:0] MAX_RESULTS = 7'd64;

	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_RADIUS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS = 2'd2;

	localparam logic [CD_W-1:0] COOLDOWN_RST = 8'd60;
	localparam logic [RAD_W-1:0] DEF_RADIUS_RST = 21'd12800;
	localparam logic [RAD_W-1:0] MAX_RADIUS_RST = 21'd1280000;

	typedef logic signed [POS_W-1:0] pos_t;

	typedef struct packed {
		pos_t cx;
		pos_t cy;
		pos_t cz;
		logic [RSQ_W-1:0] rsq;
	} geo_t;

	typedef struct packed {
		logic in_zone;
		logic [CD_W-1:0] cooldown;
	} zst_t;

endpackage

>>> hdl/szed_req_if.sv
interface szed_req_if import szed_pkg::*; ();
	logic valid;
	logic ready;
	logic [MODE_W-1:0] mode;
	pos_t pos_x;
	pos_t pos_y;
	pos_t pos_z;
	pos_t radius;

	modport source (output valid, output mode, output pos_x, output pos_y, output pos_z,
		output radius, input ready);
	modport sink (input valid, input mode, input pos_x, input pos_y, input pos_z,
		input radius, output ready);
endinterface

>>> hdl/szed_rsp_if.sv
interface szed_rsp_if import szed_pkg::*; ();
	logic valid;
	logic ready;
	logic [IDX_W-1:0] zone_index;
	logic last_fired;

	modport source (output valid, output zone_index, output last_fired, input ready);
	modport sink (input valid, input zone_index, input last_fired, output ready);
endinterface

>>> hdl/sphere_zone_entry_detector.sv
// channel   direction  payload
// req       in         mode, pos_x, pos_y, pos_z, radius
// rsp       out        zone_index, last_fired
// cfg       in         cfg_we, cfg_idx, cfg_data (write only)
//
// clear, unused modes and a load into a full table leave the block idle; a zone load writes
// the table from ST_LOAD; a tick scans the loaded zones in ST_SCAN, then ST_FLUSH if one
// fired: one table read per cycle, unless stalled, feeds the s1-s3 squared-distance stages
// arst_n clears control state and sets config to its reset values; the zone table needs no clearing pass
// the scan stalls only when a second fired zone meets a full rsp register that rsp.ready does not drain

`include "sphere_zone_entry_detector_assert.svh"

module sphere_zone_entry_detector import szed_pkg::*; #(
	parameter int NUM_ZONES = 64
) (
	input logic clk,
	input logic arst_n,
	szed_req_if.sink req,
	szed_rsp_if.source rsp,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [RAD_W-1:0] cfg_data
);

	localparam int AW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
	localparam int CW = $clog2(NUM_ZONES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	function automatic logic [POS_W-1:0] abs_diff(input pos_t a, input pos_t b);
		logic signed [POS_W:0] d;
		logic [POS_W:0] m;
		d = {a[POS_W-1], a} - {b[POS_W-1], b};
		m = d[POS_W] ? (~d + 1'b1) : d;
		return m[POS_W-1:0];
	endfunction

	logic [1:0] state_q;
	logic [CD_W-1:0] cooldown_q;
	logic [RAD_W-1:0] def_radius_q;
	logic [RAD_W-1:0] max_radius_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic [NRES_W-1:0] nres_q;
	pos_t x_q, y_q, z_q, r_q;

	geo_t geo_mem [NUM_ZONES];
	zst_t st_mem [NUM_ZONES];

	logic v_s1, v_s2, v_s3;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3;
	geo_t geo_s1;
	zst_t st_s1;
	logic [POS_W-1:0] ax_s2, ay_s2, az_s2;
	logic [RSQ_W-1:0] rsq_s2, rsq_s3;
	logic was_s2, was_s3;
	logic [CD_W-1:0] cd_s2, cd_s3;
	logic [SQ_W-1:0] sx_s3, sy_s3, sz_s3;

	logic pend_v_q;
	logic [IDX_W-1:0] pend_idx_q;
	logic out_v_q;
	logic [IDX_W-1:0] out_idx_q;
	logic out_last_q;

	logic accept, out_busy, stall, issue, load_wr, scan_done, out_load;
	logic rad_bad;
	logic [RAD_W-1:0] rad_sel;
	logic [2*RAD_W-1:0] rad_prod;
	logic [RSQ_W-1:0] rsq_new;
	logic [CD_W-1:0] cd_dec;
	logic [SUM_W-1:0] dist_sum;
	logic inside_s3, fire_s3, report_s3;
	zst_t st_wr;

	assign req.ready = (state_q == ST_IDLE);
	assign accept = req.valid && req.ready;
	assign out_busy = out_v_q && !rsp.ready;

	assign rsp.valid = out_v_q;
	assign rsp.zone_index = out_idx_q;
	assign rsp.last_fired = out_last_q;

	// radius select and square for a zone load
	always_comb begin
		rad_bad = r_q[POS_W-1] || (r_q == '0)
			|| (r_q[POS_W-2:0] > {{(POS_W-1-RAD_W){1'b0}}, max_radius_q});
		rad_sel = rad_bad ? def_radius_q : r_q[RAD_W-1:0];
		rad_prod = {{RAD_W{1'b0}}, rad_sel} * {{RAD_W{1'b0}}, rad_sel};
		rsq_new = rad_prod[2*RAD_W-1] ? {RSQ_W{1'b1}} : rad_prod[RSQ_W-1:0];
	end

	assign load_wr = (state_q == ST_LOAD);
	assign cd_dec = (st_s1.cooldown != '0) ? (st_s1.cooldown - 1'b1) : '0;

	always_comb begin
		dist_sum = {2'b00, sx_s3} + {2'b00, sy_s3} + {2'b00, sz_s3};
		inside_s3 = dist_sum < {{(SUM_W-RSQ_W){1'b0}}, rsq_s3};
		fire_s3 = !was_s3 && inside_s3 && (cd_s3 == '0);
		report_s3 = v_s3 && fire_s3 && (nres_q < MAX_RESULTS);
		st_wr.in_zone = inside_s3;
		st_wr.cooldown = fire_s3 ? cooldown_q : cd_s3;
	end

	assign stall = report_s3 && pend_v_q && out_busy;
	assign issue = (state_q == ST_SCAN) && (rd_idx_q < count_q) && !stall;
	assign scan_done = (rd_idx_q == count_q) && !v_s1 && !v_s2 && !v_s3;
	assign out_load = (report_s3 && !stall && pend_v_q) || ((state_q == ST_FLUSH) && !out_busy);

	// zone geometry table
	always_ff @(posedge clk) begin
		if (load_wr) begin
			geo_mem[count_q[AW-1:0]] <= '{cx: x_q, cy: y_q, cz: z_q, rsq: rsq_new};
		end
		if (issue) begin
			geo_s1 <= geo_mem[rd_idx_q[AW-1:0]];
		end
	end

	// zone inside flag and cooldown table
	always_ff @(posedge clk) begin
		if (load_wr) begin
			st_mem[count_q[AW-1:0]] <= '0;
		end else if (v_s3 && !stall) begin
			st_mem[idx_s3] <= st_wr;
		end
		if (issue) begin
			st_s1 <= st_mem[rd_idx_q[AW-1:0]];
		end
	end

	// distance datapath
	always_ff @(posedge clk) begin
		if (!stall) begin
			if (issue) begin
				idx_s1 <= rd_idx_q[AW-1:0];
			end
			idx_s2 <= idx_s1;
			ax_s2 <= abs_diff(x_q, geo_s1.cx);
			ay_s2 <= abs_diff(y_q, geo_s1.cy);
			az_s2 <= abs_diff(z_q, geo_s1.cz);
			rsq_s2 <= geo_s1.rsq;
			was_s2 <= st_s1.in_zone;
			cd_s2 <= cd_dec;
			idx_s3 <= idx_s2;
			sx_s3 <= {{POS_W{1'b0}}, ax_s2} * {{POS_W{1'b0}}, ax_s2};
			sy_s3 <= {{POS_W{1'b0}}, ay_s2} * {{POS_W{1'b0}}, ay_s2};
			sz_s3 <= {{POS_W{1'b0}}, az_s2} * {{POS_W{1'b0}}, az_s2};
			rsq_s3 <= rsq_s2;
			was_s3 <= was_s2;
			cd_s3 <= cd_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= req.pos_x;
			y_q <= req.pos_y;
			z_q <= req.pos_z;
			r_q <= req.radius;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q <= COOLDOWN_RST;
			def_radius_q <= DEF_RADIUS_RST;
			max_radius_q <= MAX_RADIUS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_COOLDOWN: cooldown_q <= cfg_data[CD_W-1:0];
				REG_DEF_RADIUS: def_radius_q <= cfg_data;
				REG_MAX_RADIUS: max_radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, pipeline valids and result staging
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rd_idx_q <= '0;
			nres_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			pend_v_q <= 1'b0;
			pend_idx_q <= '0;
			out_v_q <= 1'b0;
			out_idx_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (out_v_q && rsp.ready && !out_load) begin
				out_v_q <= 1'b0;
			end
			if (!stall) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
			if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (report_s3 && !stall) begin
				if (pend_v_q) begin
					out_v_q <= 1'b1;
					out_idx_q <= pend_idx_q;
					out_last_q <= 1'b0;
				end
				pend_v_q <= 1'b1;
				pend_idx_q <= IDX_W'(idx_s3);
				nres_q <= nres_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.mode)
							MODE_CLEAR: count_q <= '0;
							MODE_LOAD: begin
								if (count_q < CW'(NUM_ZONES)) begin
									state_q <= ST_LOAD;
								end
							end
							MODE_TICK: begin
								state_q <= ST_SCAN;
								rd_idx_q <= '0;
								nres_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_LOAD: begin
					count_q <= count_q + 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= pend_v_q ? ST_FLUSH : ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (!out_busy) begin
						out_v_q <= 1'b1;
						out_idx_q <= pend_idx_q;
						out_last_q <= 1'b1;
						pend_v_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SZED_ASSERT_NOW(a_idle_pipe_empty, clk, arst_n, req.ready, !v_s1 && !v_s2 && !v_s3 && !pend_v_q)
	`SZED_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(NUM_ZONES))
	`SZED_ASSERT_NOW(a_scan_idx_bound, clk, arst_n, state_q == ST_SCAN, rd_idx_q <= count_q)
	`SZED_ASSERT_NOW(a_result_bound, clk, arst_n, 1'b1, nres_q <= MAX_RESULTS)
	`SZED_ASSERT_NXT(a_stall_holds_out, clk, arst_n, stall, out_v_q && $stable(out_idx_q))

endmodule
